// File: design/image_scale_by_two_top_defines.svh
// assertion macros for the image scale-by-two block
// used by the port checker; no other dependencies
`ifndef IMAGE_SCALE_BY_TWO_TOP_DEFINES_SVH
`define IMAGE_SCALE_BY_TWO_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ISB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ISB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/isb_pkg.sv
// shared types and constants of the image scale-by-two block
// no dependencies
package isb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int PIX_W          = 8;
    localparam int DIM_W          = 11;
    localparam int MODE_W         = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int SUB_W          = 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [MODE_W-1:0] MODE_HALF_W    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HALF_H    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF_BOTH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DBL_W     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DBL_H     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DBL_BOTH  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

    localparam logic [DIM_W-1:0] RST_SRC_DIM = 11'd1024;

    // how the back end expands one job into output pixels
    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_DUP_COL,
        KIND_DUP_ROW,
        KIND_DUP_BOTH
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [PIX_W-1:0]  pixel;
        logic [DIM_W-1:0]  col;
        logic [DIM_W-1:0]  row;
        logic              frame_end;
    } t_job;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              restart;
    } t_cfg_ctl;

endpackage

// File: design/isb_ifs.sv
// valid/ready channel interfaces of the image scale-by-two block
// depends on isb_pkg
interface isb_in_if import isb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface isb_out_if import isb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic [DIM_W-1:0] out_col;
    logic [DIM_W-1:0] out_row;
    logic             run_last;
    logic             frame_end;

    modport source (output valid, output pixel_out, output out_col, output out_row,
                    output run_last, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input out_col, input out_row,
                    input run_last, input frame_end, output ready);
endinterface

interface isb_cfg_if import isb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/isb_cfg.sv
// configuration registers: mode and clamped source dimensions
// depends on isb_pkg and isb_ifs
module isb_cfg import isb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    isb_cfg_if.sink                       i_cfg,
    output t_cfg_ctl                      o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_w_last,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_w_pair_last,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_h_last,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_h_pair_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WEW   = $clog2(MAX_WIDTH + 1);
    localparam int HEW   = $clog2(MAX_HEIGHT + 1);
    localparam int EW0   = (WEW > HEW) ? WEW : HEW;
    localparam int EW    = (EW0 > DIM_W) ? EW0 : DIM_W;

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [EW-1:0] f_eff(input logic [DIM_W-1:0] v,
                                            input logic [EW-1:0] maxv);
        logic [EW-1:0] ve;
        ve = EW'(v);
        if (v == '0)
            f_eff = EW'(1);
        else if (ve > maxv)
            f_eff = maxv;
        else
            f_eff = ve;
    endfunction

    logic [MODE_W-1:0] r_mode;
    logic [CW-1:0]     r_w_last, r_w_pair_last;
    logic [RW-1:0]     r_h_last, r_h_pair_last;
    logic [EW-1:0]     w_eff, h_eff, w_rst, h_rst;
    logic              wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;
    assign w_eff       = f_eff(i_cfg.data, EW'(MAX_WIDTH));
    assign h_eff       = f_eff(i_cfg.data, EW'(MAX_HEIGHT));
    assign w_rst       = f_eff(RST_SRC_DIM, EW'(MAX_WIDTH));
    assign h_rst       = f_eff(RST_SRC_DIM, EW'(MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_HALF_W;
            r_w_last      <= CW'(w_rst - EW'(1));
            r_w_pair_last <= CW'((w_rst & ~EW'(1)) - EW'(1));
            r_h_last      <= RW'(h_rst - EW'(1));
            r_h_pair_last <= RW'((h_rst & ~EW'(1)) - EW'(1));
        end else if (wr) begin
            unique case (i_cfg.index)
                REG_MODE: begin
                    r_mode <= i_cfg.data[MODE_W-1:0];
                end
                REG_SRC_WIDTH: begin
                    r_w_last      <= CW'(w_eff - EW'(1));
                    r_w_pair_last <= CW'((w_eff & ~EW'(1)) - EW'(1));
                end
                REG_SRC_HEIGHT: begin
                    r_h_last      <= RW'(h_eff - EW'(1));
                    r_h_pair_last <= RW'((h_eff & ~EW'(1)) - EW'(1));
                end
                default: begin
                end
            endcase
        end
    end

    // any write to an existing register restarts the frame
    assign o_ctl.restart = wr && (i_cfg.index == REG_MODE || i_cfg.index == REG_SRC_WIDTH ||
                                  i_cfg.index == REG_SRC_HEIGHT);
    assign o_ctl.mode    = r_mode;
    assign o_w_last      = r_w_last;
    assign o_w_pair_last = r_w_pair_last;
    assign o_h_last      = r_h_last;
    assign o_h_pair_last = r_h_pair_last;

endmodule

// File: design/isb_front.sv
// front end: position counters, line store and pair averaging
// classifies each source pixel into a job; depends on isb_pkg and isb_ifs
module isb_front import isb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    isb_in_if.sink                        i_pix,
    input  t_cfg_ctl                      i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_w_last,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_w_pair_last,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_h_last,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_h_pair_last,
    output logic                          o_job_valid,
    output t_job                          o_job,
    input  logic                          i_job_ready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SUM_W = PIX_W + 1;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_AVG2,
        OP_AVG4
    } t_op;

    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [PIX_W-1:0] r_left;
    logic [SUM_W-1:0] r_line [MAX_WIDTH];
    logic [SUM_W-1:0] r_rd;

    logic             r_b_valid;
    t_op              r_b_op;
    logic [SUM_W-1:0] r_b_acc;
    t_job             r_b_job;

    logic             accept;
    logic             col_last, row_last, col_pair_last, row_pair_last;
    logic [SUM_W-1:0] pair_sum;
    logic [SUM_W:0]   mem_sum;
    logic [CW-1:0]    mem_addr;
    logic [SUM_W-1:0] mem_wdata;
    logic             mem_we, mem_re, left_we, produce;
    t_op              a_op;
    logic [SUM_W-1:0] a_acc;
    t_job             a_job;

    assign i_pix.ready   = !r_b_valid || i_job_ready;
    assign accept        = i_pix.valid && i_pix.ready;
    assign col_last      = (r_col == i_w_last);
    assign row_last      = (r_row == i_h_last);
    assign col_pair_last = (r_col == i_w_pair_last);
    assign row_pair_last = (r_row == i_h_pair_last);
    assign pair_sum      = {1'b0, r_left} + {1'b0, i_pix.pixel_in};

    always_comb begin
        produce         = 1'b0;
        left_we         = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = r_col;
        mem_wdata       = {1'b0, i_pix.pixel_in};
        a_op            = OP_PASS;
        a_acc           = {1'b0, i_pix.pixel_in};
        a_job.kind      = KIND_ONE;
        a_job.pixel     = i_pix.pixel_in;
        a_job.col       = DIM_W'(r_col);
        a_job.row       = DIM_W'(r_row);
        a_job.frame_end = col_last && row_last;
        unique case (i_ctl.mode)
            MODE_HALF_W: begin
                if (!r_col[0]) begin
                    left_we = 1'b1;
                end else begin
                    produce         = 1'b1;
                    a_acc           = pair_sum >> 1;
                    a_job.col       = DIM_W'(r_col >> 1);
                    a_job.frame_end = row_last && col_pair_last;
                end
            end
            MODE_HALF_H: begin
                if (!r_row[0]) begin
                    mem_we = 1'b1;
                end else begin
                    produce         = 1'b1;
                    mem_re          = 1'b1;
                    a_op            = OP_AVG2;
                    a_job.row       = DIM_W'(r_row >> 1);
                    a_job.frame_end = row_pair_last && col_last;
                end
            end
            MODE_HALF_BOTH: begin
                // line store holds horizontal pair sums of the even row
                mem_addr  = CW'(r_col >> 1);
                mem_wdata = pair_sum;
                if (!r_col[0]) begin
                    left_we = 1'b1;
                end else if (!r_row[0]) begin
                    mem_we = 1'b1;
                end else begin
                    produce         = 1'b1;
                    mem_re          = 1'b1;
                    a_op            = OP_AVG4;
                    a_acc           = pair_sum;
                    a_job.col       = DIM_W'(r_col >> 1);
                    a_job.row       = DIM_W'(r_row >> 1);
                    a_job.frame_end = row_pair_last && col_pair_last;
                end
            end
            MODE_DBL_W: begin
                produce    = 1'b1;
                a_job.kind = KIND_DUP_COL;
                a_job.col  = DIM_W'({r_col, 1'b0});
            end
            MODE_DBL_H: begin
                produce    = 1'b1;
                a_job.kind = KIND_DUP_ROW;
                a_job.row  = DIM_W'({r_row, 1'b0});
            end
            MODE_DBL_BOTH: begin
                produce    = 1'b1;
                a_job.kind = KIND_DUP_BOTH;
                a_job.col  = DIM_W'({r_col, 1'b0});
                a_job.row  = DIM_W'({r_row, 1'b0});
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_ctl.restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_left    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept && left_we) begin
                r_left <= i_pix.pixel_in;
            end
            if (i_pix.ready) begin
                r_b_valid <= accept && produce;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_op  <= a_op;
            r_b_acc <= a_acc;
            r_b_job <= a_job;
        end
    end

    // line store, one port, read data held until the next transfer
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_line[mem_addr] <= mem_wdata;
        end
        if (accept && mem_re) begin
            r_rd <= r_line[mem_addr];
        end
    end

    assign mem_sum = {1'b0, r_rd} + {1'b0, r_b_acc};

    always_comb begin
        o_job = r_b_job;
        unique case (r_b_op)
            OP_AVG2: o_job.pixel = mem_sum[PIX_W:1];
            OP_AVG4: o_job.pixel = mem_sum[PIX_W+1:2];
            default: o_job.pixel = r_b_acc[PIX_W-1:0];
        endcase
    end

    assign o_job_valid = r_b_valid;

endmodule

// File: design/isb_fifo.sv
// small job queue between front and back end
// depends on isb_pkg
module isb_fifo import isb_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_data,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_data,
    input  logic i_pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

// File: design/isb_back.sv
// back end: expands each job into one, two or four output pixels
// with a registered output stage; depends on isb_pkg and isb_ifs
module isb_back import isb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_ready,
    isb_out_if.source  o_pix
);

    t_job             r_cur;
    logic             r_cur_valid;
    logic [SUB_W-1:0] r_k;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_pix;
    logic [DIM_W-1:0] r_ocol, r_orow;
    logic             r_run_last, r_fend;

    logic             emit, sub_last, take, col_off, row_off;
    logic [SUB_W-1:0] k_last;

    always_comb begin
        unique case (r_cur.kind)
            KIND_ONE: begin
                k_last  = SUB_W'(0);
                col_off = 1'b0;
                row_off = 1'b0;
            end
            KIND_DUP_COL: begin
                k_last  = SUB_W'(1);
                col_off = r_k[0];
                row_off = 1'b0;
            end
            KIND_DUP_ROW: begin
                k_last  = SUB_W'(1);
                col_off = 1'b0;
                row_off = r_k[0];
            end
            KIND_DUP_BOTH: begin
                k_last  = SUB_W'(3);
                col_off = r_k[0];
                row_off = r_k[1];
            end
        endcase
    end

    assign emit        = r_cur_valid && (!r_out_valid || o_pix.ready);
    assign sub_last    = (r_k == k_last);
    assign take        = !r_cur_valid || (emit && sub_last);
    assign o_job_ready = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_cur_valid <= i_job_valid;
                r_k         <= '0;
            end else if (emit) begin
                r_k <= r_k + SUB_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_job_valid) begin
            r_cur <= i_job;
        end
        // base coordinates of duplicated jobs are even, so the offset is an or
        if (emit) begin
            r_pix      <= r_cur.pixel;
            r_ocol     <= r_cur.col | DIM_W'(col_off);
            r_orow     <= r_cur.row | DIM_W'(row_off);
            r_run_last <= sub_last;
            r_fend     <= sub_last && r_cur.frame_end;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pixel_out = r_pix;
    assign o_pix.out_col   = r_ocol;
    assign o_pix.out_row   = r_orow;
    assign o_pix.run_last  = r_run_last;
    assign o_pix.frame_end = r_fend;

endmodule

// File: design/image_scale_by_two_top.sv
// Streaming 2x down/up scaler for 8-bit grey images in raster order. The input
// port can take one source pixel per cycle while the job queue has room; the output
// port gives one result per cycle while the receiver is ready, so the sustained rate is
// one pixel per cycle in the halving modes; in the doubling modes it is set by the back
// end, which emits one output pixel per cycle. A pixel passes the front-end job register,
// the job queue, the current job register and the output register on its way out. The
// line store is a single-port memory of MAX_WIDTH x 9 bits with no clearing pass; it is
// always written earlier in the frame before it is read. The user must write registers
// (mode, src_width, src_height) through the config channel only while the block is idle;
// the block itself does not enforce this. Every write to one of them restarts the frame
// at row 0, column 0.
module image_scale_by_two_top import isb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isb_cfg_if.sink   i_cfg,
    isb_in_if.sink    i_pix,
    isb_out_if.source o_pix
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    t_cfg_ctl      cfg_ctl;
    logic [CW-1:0] w_last, w_pair_last;
    logic [RW-1:0] h_last, h_pair_last;
    logic          fj_valid, fj_ready, bj_valid, bj_ready;
    t_job          fj_data, bj_data;

    isb_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .o_ctl         (cfg_ctl),
        .o_w_last      (w_last),
        .o_w_pair_last (w_pair_last),
        .o_h_last      (h_last),
        .o_h_pair_last (h_pair_last)
    );

    isb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (i_pix),
        .i_ctl         (cfg_ctl),
        .i_w_last      (w_last),
        .i_w_pair_last (w_pair_last),
        .i_h_last      (h_last),
        .i_h_pair_last (h_pair_last),
        .o_job_valid   (fj_valid),
        .o_job         (fj_data),
        .i_job_ready   (fj_ready)
    );

    isb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fj_valid),
        .i_push_data  (fj_data),
        .o_push_ready (fj_ready),
        .o_pop_valid  (bj_valid),
        .o_pop_data   (bj_data),
        .i_pop_ready  (bj_ready)
    );

    isb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (bj_valid),
        .i_job       (bj_data),
        .o_job_ready (bj_ready),
        .o_pix       (o_pix)
    );

endmodule

// File: design/isb_checker.sv
// port checker for the image scale-by-two block, bound to the top level
// depends on isb_pkg and image_scale_by_two_top_defines.svh
`include "image_scale_by_two_top_defines.svh"

module isb_checker import isb_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_pixel_out,
    input logic             i_run_last,
    input logic             i_frame_end
);

    `ISB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output dropped while stalled")

    `ISB_ASSERT_IMP(a_fend_last, i_clk, i_rst_n, i_out_valid && i_frame_end, i_run_last, "frame end off the last result of a pixel")

    // the rest of a replicated run follows without a gap
    `ISB_ASSERT_NXT(a_run_cont, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_run_last, i_out_valid, "gap inside a replicated run")

    `ISB_ASSERT_NXT(a_run_pix, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_run_last, i_pixel_out == $past(i_pixel_out), "pixel value changed inside a run")

endmodule

bind image_scale_by_two_top isb_checker u_isb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pixel_out (o_pix.pixel_out),
    .i_run_last  (o_pix.run_last),
    .i_frame_end (o_pix.frame_end)
);

// File: sim/image_scale_by_two_top_tb.sv
`timescale 1ns / 100ps
// testbench for the image scale-by-two block: drives source pixels and register writes,
// predicts every output pixel with its coordinates and flags, and checks them in order
// depends on isb_pkg, isb_ifs and image_scale_by_two_top
module image_scale_by_two_top_tb;
    import isb_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_OFF_LO  = 3'd0;
    localparam logic [MODE_W-1:0]    MODE_OFF_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam int                   RAND_ITEMS   = 40;
    localparam int                   PRESS_ITEMS  = 16;
    localparam int                   HOLD_CYCLES  = 400;
    localparam int                   WATCHDOG_MAX = 4000;
    localparam int                   DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic             run_last;
        logic             frame_end;
    } t_scaled_pix;

    logic i_clk;
    logic i_rst_n;

    isb_cfg_if cfg_bus ();
    isb_in_if  pix_bus ();
    isb_out_if res_bus ();

    image_scale_by_two_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_pix   (res_bus)
    );

    // source pixels waiting to be offered, and output pixels still owed by the block
    logic [PIX_W-1:0] src_q[$];
    t_scaled_pix      scaled_q[$];

    // scaler state as seen from outside
    logic [MODE_W-1:0] scl_mode;
    logic [DIM_W-1:0]  scl_w;
    logic [DIM_W-1:0]  scl_h;
    int                next_col;
    int                next_row;
    logic [PIX_W-1:0]  pair_left;
    logic [8:0]        row_mem [0:DEF_MAX_WIDTH-1];

    int   err_cnt;
    int   snd_idle_pct;
    int   rcv_idle_pct;
    bit   hold_go;
    logic out_hold;
    int   quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        if (err_cnt < 100)
            $display("ERROR %0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int max_v);
        if (v == 0)
            return 1;
        if (v > max_v)
            return max_v;
        return v;
    endfunction

    task automatic add_result(input int pix, input int col, input int row, input bit last,
                              input bit fend);
        t_scaled_pix e;
        e.pixel     = PIX_W'(pix);
        e.col       = DIM_W'(col);
        e.row       = DIM_W'(row);
        e.run_last  = last;
        e.frame_end = fend;
        scaled_q.push_back(e);
    endtask

    task automatic scale_pixel(input logic [PIX_W-1:0] p);
        int w;
        int h;
        int c;
        int r;
        int sum;
        bit last_src;
        w = eff_dim(scl_w, DEF_MAX_WIDTH);
        h = eff_dim(scl_h, DEF_MAX_HEIGHT);
        c = next_col;
        r = next_row;
        last_src = (c == w - 1) && (r == h - 1);
        case (scl_mode)
            MODE_HALF_W: begin
                if (c % 2 == 0) begin
                    pair_left = p;
                end else begin
                    sum = int'(pair_left) + int'(p);
                    add_result(sum / 2, c / 2, r, 1'b1, r == h - 1 && c / 2 == w / 2 - 1);
                end
            end
            MODE_HALF_H: begin
                if (r % 2 == 0) begin
                    row_mem[c] = 9'(p);
                end else begin
                    sum = int'(row_mem[c]) + int'(p);
                    add_result(sum / 2, c, r / 2, 1'b1, r / 2 == h / 2 - 1 && c == w - 1);
                end
            end
            MODE_HALF_BOTH: begin
                if (c % 2 == 0) begin
                    pair_left = p;
                end else if (r % 2 == 0) begin
                    // even rows leave the pair sum for the row below
                    row_mem[c / 2] = 9'(int'(pair_left) + int'(p));
                end else begin
                    sum = int'(row_mem[c / 2]) + int'(pair_left) + int'(p);
                    add_result(sum / 4, c / 2, r / 2, 1'b1,
                               r / 2 == h / 2 - 1 && c / 2 == w / 2 - 1);
                end
            end
            MODE_DBL_W: begin
                add_result(p, 2 * c, r, 1'b0, 1'b0);
                add_result(p, 2 * c + 1, r, 1'b1, last_src);
            end
            MODE_DBL_H: begin
                add_result(p, c, 2 * r, 1'b0, 1'b0);
                add_result(p, c, 2 * r + 1, 1'b1, last_src);
            end
            MODE_DBL_BOTH: begin
                add_result(p, 2 * c, 2 * r, 1'b0, 1'b0);
                add_result(p, 2 * c + 1, 2 * r, 1'b0, 1'b0);
                add_result(p, 2 * c, 2 * r + 1, 1'b0, 1'b0);
                add_result(p, 2 * c + 1, 2 * r + 1, 1'b1, last_src);
            end
            default: begin
                // unused modes swallow the pixel
            end
        endcase
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        next_col = c;
        next_row = r;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        case (idx)
            REG_MODE:       scl_mode = val[MODE_W-1:0];
            REG_SRC_WIDTH:  scl_w    = val;
            REG_SRC_HEIGHT: scl_h    = val;
            default:        ;
        endcase
        // any write to a real register restarts the frame
        if (idx != REG_UNUSED) begin
            next_col = 0;
            next_row = 0;
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] mode_val, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
        write_reg(REG_MODE, mode_val);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
    endtask

    // wait for every pixel to be taken and every result to come back
    task automatic settle(input int extra);
        @(posedge i_clk);
        while (src_q.size() != 0 || pix_bus.valid || scaled_q.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_idle(input int prof);
        case (prof)
            0: begin
                snd_idle_pct = 20;
                rcv_idle_pct = 80;
            end
            1: begin
                snd_idle_pct = 80;
                rcv_idle_pct = 20;
            end
            default: begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
        endcase
    endtask

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready)
                scale_pixel(pix_bus.pixel_in);
            if (!pix_bus.valid || pix_bus.ready) begin
                if (src_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    pix_bus.valid    <= 1'b1;
                    pix_bus.pixel_in <= src_q.pop_front();
                end else begin
                    pix_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_scaled_pix want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= !out_hold && ($urandom_range(0, 99) >= rcv_idle_pct);
            if (res_bus.valid && res_bus.ready) begin
                if (scaled_q.size() == 0) begin
                    report_error($sformatf("unexpected pixel %0d at col %0d row %0d",
                                           res_bus.pixel_out, res_bus.out_col,
                                           res_bus.out_row));
                end else begin
                    want = scaled_q.pop_front();
                    if (res_bus.pixel_out !== want.pixel)
                        report_error($sformatf("pixel_out %0d, want %0d at col %0d row %0d",
                                               res_bus.pixel_out, want.pixel, want.col,
                                               want.row));
                    if (res_bus.out_col !== want.col)
                        report_error($sformatf("out_col %0d, want %0d at row %0d",
                                               res_bus.out_col, want.col, want.row));
                    if (res_bus.out_row !== want.row)
                        report_error($sformatf("out_row %0d, want %0d at col %0d",
                                               res_bus.out_row, want.row, want.col));
                    if (res_bus.run_last !== want.run_last)
                        report_error($sformatf("run_last %b, want %b at col %0d row %0d",
                                               res_bus.run_last, want.run_last, want.col,
                                               want.row));
                    if (res_bus.frame_end !== want.frame_end)
                        report_error($sformatf("frame_end %b, want %b at col %0d row %0d",
                                               res_bus.frame_end, want.frame_end, want.col,
                                               want.row));
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        out_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
                     (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int               rand_cnt;
        int               area;
        int               n;
        logic [MODE_W-1:0] m;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;

        i_rst_n          <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_MODE;
        cfg_bus.data     <= '0;
        err_cnt   = 0;
        hold_go   = 1'b0;
        scl_mode  = MODE_HALF_W;
        scl_w     = RST_SRC_DIM;
        scl_h     = RST_SRC_DIM;
        next_col  = 0;
        next_row  = 0;
        pair_left = '0;
        rand_cnt  = 0;
        set_idle(0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: half width over a 1024 wide frame
        src_q.push_back(8'd0);
        src_q.push_back(8'd255);
        settle(DRAIN_CYCLES);

        // write to a missing register must not restart the frame
        write_reg(REG_UNUSED, 11'h7FF);
        src_q.push_back(8'hFF);
        src_q.push_back(8'hFE);
        settle(DRAIN_CYCLES);

        // odd last column and row dropped, full-scale sum, then frame wrap
        set_frame(DIM_W'(MODE_HALF_BOTH), 11'd3, 11'd3);
        repeat (9) src_q.push_back(8'hFF);
        settle(DRAIN_CYCLES);

        // width zero taken as one
        set_frame(DIM_W'(MODE_HALF_H), 11'd0, 11'd2);
        src_q.push_back(8'hFF);
        src_q.push_back(8'h00);
        settle(DRAIN_CYCLES);

        set_frame(DIM_W'(MODE_DBL_W), 11'd2, 11'd1);
        src_q.push_back(8'h5A);
        src_q.push_back(8'hA5);
        settle(DRAIN_CYCLES);

        // height zero taken as one, every pixel ends a frame
        set_frame(DIM_W'(MODE_DBL_H), 11'd1, 11'd0);
        src_q.push_back(8'h01);
        src_q.push_back(8'h80);
        settle(DRAIN_CYCLES);

        set_frame(DIM_W'(MODE_DBL_BOTH), 11'd2, 11'd1);
        src_q.push_back(8'h7F);
        src_q.push_back(8'h00);
        settle(DRAIN_CYCLES);

        // unused modes give nothing
        set_frame(DIM_W'(MODE_OFF_LO), 11'd2, 11'd2);
        src_q.push_back(8'h33);
        src_q.push_back(8'hCC);
        settle(DRAIN_CYCLES);
        write_reg(REG_MODE, DIM_W'(MODE_OFF_HI));
        src_q.push_back(8'h96);
        settle(DRAIN_CYCLES);

        // random frames, mostly small, usually one or two full frames
        while (rand_cnt < RAND_ITEMS) begin
            set_idle(rand_cnt * 3 / RAND_ITEMS);
            if ($urandom_range(0, 9) != 0)
                m = MODE_W'($urandom_range(1, 6));
            else
                m = $urandom_range(0, 1) ? MODE_OFF_HI : MODE_OFF_LO;
            w = DIM_W'($urandom_range(0, 5));
            h = DIM_W'($urandom_range(0, 4));
            area = eff_dim(w, DEF_MAX_WIDTH) * eff_dim(h, DEF_MAX_HEIGHT);
            n = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
            // upper bits of a mode write are ignored
            set_frame({8'($urandom_range(0, 255)), m}, w, h);
            repeat (n) src_q.push_back(PIX_W'($urandom_range(0, 255)));
            if (m != MODE_OFF_LO && m != MODE_OFF_HI)
                rand_cnt += n;
            settle(DRAIN_CYCLES);
        end

        // receiver holds off while the sender keeps offering, oversize width taken as
        // the maximum
        set_idle(2);
        set_frame(DIM_W'(MODE_DBL_BOTH), 11'h7FF, 11'd2);
        hold_go = 1'b1;
        repeat (PRESS_ITEMS) src_q.push_back(PIX_W'($urandom_range(0, 255)));
        settle(20);

        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/isb_pkg.sv
design/isb_ifs.sv
design/isb_cfg.sv
design/isb_front.sv
design/isb_fifo.sv
design/isb_back.sv
design/image_scale_by_two_top.sv
design/isb_checker.sv
sim/image_scale_by_two_top_tb.sv
